// File: rtl/hrrn_pkg.sv
package hrrn_pkg;

   // Table geometry.
   localparam int JOB_SLOTS = 16;
   localparam int SLOT_W = (JOB_SLOTS > 1) ? $clog2(JOB_SLOTS) : 1;
   localparam int USED_W = $clog2(JOB_SLOTS + 1);
   localparam int MAX_PICKS = 16;
   localparam int CNT_W = $clog2(MAX_PICKS + 1);

   // Field widths.
   localparam int ACTION_W = 2;
   localparam int TAG_W = 24;
   localparam int MEM_W = 20;
   localparam int DEV_W = 4;
   localparam int TIME_W = 16;
   localparam int NUM_W = TIME_W + 1;
   localparam int DEN_W = TIME_W;
   localparam int PROD_W = NUM_W + DEN_W;
   localparam int KIND_W = 2;
   localparam int STATUS_W = 2;
   localparam int OUT_SLOT_W = 6;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DATA_W = 20;

   // Pool values after reset.
   localparam logic [MEM_W-1:0] RESET_MEMORY = MEM_W'(65536);
   localparam logic [DEV_W-1:0] RESET_TAPES = DEV_W'(4);
   localparam logic [DEV_W-1:0] RESET_PRINTERS = DEV_W'(2);

   // Action codes.
   localparam logic [ACTION_W-1:0] ACT_ADD = 2'd0;
   localparam logic [ACTION_W-1:0] ACT_SCHEDULE = 2'd1;
   localparam logic [ACTION_W-1:0] ACT_CLEAR = 2'd2;
   localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;

   // Result kinds.
   localparam logic [KIND_W-1:0] KIND_ADD_ACK = 2'd0;
   localparam logic [KIND_W-1:0] KIND_PICKED = 2'd1;
   localparam logic [KIND_W-1:0] KIND_NONE_FITS = 2'd2;
   localparam logic [KIND_W-1:0] KIND_CLEARED = 2'd3;

   // Add status codes.
   localparam logic [STATUS_W-1:0] STAT_OK = 2'd0;
   localparam logic [STATUS_W-1:0] STAT_FULL = 2'd1;
   localparam logic [STATUS_W-1:0] STAT_ZERO_RUN = 2'd2;

   // Register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_TOTAL_MEMORY = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_TOTAL_TAPES = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_TOTAL_PRINTERS = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FETCH,
      ST_MUL1,
      ST_MUL2,
      ST_CMP,
      ST_PICK,
      ST_FLUSH
   } hrrn_state_type;

   typedef struct packed {
      logic load_first;
      logic load_second;
   } hrrn_mul_ctrl_type;

endpackage

// File: rtl/hrrn_ratio_cmp.sv
module hrrn_ratio_cmp (
   input  logic                          clock,
   input  hrrn_pkg::hrrn_mul_ctrl_type   ctrl,
   input  logic [hrrn_pkg::NUM_W-1:0]    cand_num,
   input  logic [hrrn_pkg::DEN_W-1:0]    cand_den,
   input  logic [hrrn_pkg::NUM_W-1:0]    best_num,
   input  logic [hrrn_pkg::DEN_W-1:0]    best_den,
   output logic                          cand_wins
);
   import hrrn_pkg::*;

   logic [NUM_W-1:0]  mul_a;
   logic [DEN_W-1:0]  mul_b;
   logic [PROD_W-1:0] product;
   logic [PROD_W-1:0] prod_first_ff;
   logic [PROD_W-1:0] prod_second_ff;

   // One multiplier forms both cross products on successive cycles.
   always_comb begin
      if (ctrl.load_first) begin
         mul_a = cand_num;
         mul_b = best_den;
      end else begin
         mul_a = best_num;
         mul_b = cand_den;
      end
      product = PROD_W'(mul_a) * PROD_W'(mul_b);
   end

   always_ff @(posedge clock) begin
      if (ctrl.load_first) begin
         prod_first_ff <= product;
      end
      if (ctrl.load_second) begin
         prod_second_ff <= product;
      end
   end

   // A strict compare keeps the earlier job of the scan on a tie.
   assign cand_wins = prod_first_ff > prod_second_ff;

endmodule

// File: rtl/hrrn_job_scheduler.sv
// Highest-response-ratio-next job admission scheduler.
// Commands arrive on the req_ ports and transfer at a rising edge with start high
// and busy low. Action add stores a job in the next unused slot, action schedule
// admits jobs that fit the free pool, action clear empties the table and reloads
// the pool from the csr_ registers. Action code 3 is ignored and gives no result.
// Each result is shown on the rsp_ ports for exactly one cycle with rsp_valid
// high; the receiver cannot stall, so every result transfers in that cycle.
// rsp_last marks the final result of a command.
// Add and clear answer in the cycle after the transfer, and the next command may
// follow right away. A schedule command runs up to 16 passes over the table,
// one per admitted job. In a pass each slot is fetched, and a fitting job
// after the first fit of that pass also passes through the MUL1, MUL2 and CMP
// states because the single shared multiplier forms the two cross products in
// turn. Each pass ends with a pick state, and a flush state follows the
// sixteenth pick. Every pick empties a slot, so the worst case for busy is a
// table of sixteen fitting jobs. Configuration writes are always ready and reach
// the pool only at a clear. Reset is synchronous: the table is emptied and the
// pool takes 65536 memory units, 4 tapes and 2 printers. Each picked result of a
// schedule is held one pass so that its last flag is known when it is shown.
module hrrn_job_scheduler (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   output logic                               busy,
   input  logic [hrrn_pkg::ACTION_W-1:0]      req_action,
   input  logic [hrrn_pkg::TAG_W-1:0]         req_job_tag,
   input  logic [hrrn_pkg::MEM_W-1:0]         req_mem_need,
   input  logic [hrrn_pkg::DEV_W-1:0]         req_tape_need,
   input  logic [hrrn_pkg::DEV_W-1:0]         req_printer_need,
   input  logic [hrrn_pkg::TIME_W-1:0]        req_wait_time,
   input  logic [hrrn_pkg::TIME_W-1:0]        req_run_time,
   output logic                               rsp_valid,
   output logic [hrrn_pkg::KIND_W-1:0]        rsp_kind,
   output logic [hrrn_pkg::STATUS_W-1:0]      rsp_status,
   output logic [hrrn_pkg::TAG_W-1:0]         rsp_picked_tag,
   output logic [hrrn_pkg::OUT_SLOT_W-1:0]    rsp_picked_slot,
   output logic [hrrn_pkg::MEM_W-1:0]         rsp_free_memory,
   output logic                               rsp_last,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [hrrn_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [hrrn_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import hrrn_pkg::*;

   // Sequencer state.
   hrrn_state_type state_ff, state_in;
   logic [SLOT_W-1:0] scan_idx_ff, scan_idx_in;
   logic [CNT_W-1:0]  count_ff, count_in;

   // Best job of the current pass.
   logic              best_found_ff, best_found_in;
   logic [SLOT_W-1:0] best_idx_ff, best_idx_in;
   logic [TAG_W-1:0]  best_tag_ff, best_tag_in;
   logic [MEM_W-1:0]  best_mem_ff, best_mem_in;
   logic [DEV_W-1:0]  best_tape_ff, best_tape_in;
   logic [DEV_W-1:0]  best_prn_ff, best_prn_in;
   logic [NUM_W-1:0]  best_num_ff, best_num_in;
   logic [DEN_W-1:0]  best_den_ff, best_den_in;

   // Candidate under comparison.
   logic [TAG_W-1:0]  cand_tag_ff, cand_tag_in;
   logic [MEM_W-1:0]  cand_mem_ff, cand_mem_in;
   logic [DEV_W-1:0]  cand_tape_ff, cand_tape_in;
   logic [DEV_W-1:0]  cand_prn_ff, cand_prn_in;
   logic [NUM_W-1:0]  cand_num_ff, cand_num_in;
   logic [DEN_W-1:0]  cand_den_ff, cand_den_in;

   // Pick held back until its last flag is known.
   logic              pend_valid_ff, pend_valid_in;
   logic [TAG_W-1:0]  pend_tag_ff, pend_tag_in;
   logic [SLOT_W-1:0] pend_slot_ff, pend_slot_in;
   logic [MEM_W-1:0]  pend_mem_ff, pend_mem_in;

   // Job table.
   logic [JOB_SLOTS-1:0] slot_valid_ff, slot_valid_in;
   logic [TAG_W-1:0]     job_tag_ff  [JOB_SLOTS];
   logic [MEM_W-1:0]     job_mem_ff  [JOB_SLOTS];
   logic [DEV_W-1:0]     job_tape_ff [JOB_SLOTS];
   logic [DEV_W-1:0]     job_prn_ff  [JOB_SLOTS];
   logic [TIME_W-1:0]    job_wait_ff [JOB_SLOTS];
   logic [TIME_W-1:0]    job_run_ff  [JOB_SLOTS];
   logic                 job_we;
   logic [USED_W-1:0]    slots_used_ff, slots_used_in;

   // Resource pool and its configured totals.
   logic [MEM_W-1:0] mem_free_ff, mem_free_in;
   logic [DEV_W-1:0] tapes_free_ff, tapes_free_in;
   logic [DEV_W-1:0] printers_free_ff, printers_free_in;
   logic [MEM_W-1:0] total_memory_ff;
   logic [DEV_W-1:0] total_tapes_ff;
   logic [DEV_W-1:0] total_printers_ff;

   // Result register.
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [KIND_W-1:0]     rsp_kind_ff, rsp_kind_in;
   logic [STATUS_W-1:0]   rsp_status_ff, rsp_status_in;
   logic [TAG_W-1:0]      rsp_tag_ff, rsp_tag_in;
   logic [OUT_SLOT_W-1:0] rsp_slot_ff, rsp_slot_in;
   logic [MEM_W-1:0]      rsp_mem_ff, rsp_mem_in;
   logic                  rsp_last_ff, rsp_last_in;

   // Table read at the scan position.
   logic [TAG_W-1:0]  rd_tag;
   logic [MEM_W-1:0]  rd_mem;
   logic [DEV_W-1:0]  rd_tape;
   logic [DEV_W-1:0]  rd_prn;
   logic [NUM_W-1:0]  rd_num;
   logic [DEN_W-1:0]  rd_den;
   logic              rd_fits;

   logic              accept;
   logic              table_full;
   logic              cand_wins;
   logic              scan_done;
   logic [MEM_W-1:0]  mem_after_pick;
   hrrn_mul_ctrl_type mul_ctrl;

   assign accept     = start && !busy;
   assign busy       = state_ff != ST_IDLE;
   assign csr_ready  = 1'b1;
   assign table_full = slots_used_ff >= USED_W'(JOB_SLOTS);
   assign scan_done  = scan_idx_ff == '0;
   assign mem_after_pick = mem_free_ff - best_mem_ff;

   assign rd_tag  = job_tag_ff[scan_idx_ff];
   assign rd_mem  = job_mem_ff[scan_idx_ff];
   assign rd_tape = job_tape_ff[scan_idx_ff];
   assign rd_prn  = job_prn_ff[scan_idx_ff];
   assign rd_den  = job_run_ff[scan_idx_ff];
   assign rd_num  = NUM_W'(job_wait_ff[scan_idx_ff]) + NUM_W'(job_run_ff[scan_idx_ff]);
   assign rd_fits = slot_valid_ff[scan_idx_ff] && (rd_mem <= mem_free_ff) &&
                    (rd_tape <= tapes_free_ff) && (rd_prn <= printers_free_ff);

   hrrn_ratio_cmp u_ratio_cmp (
      .clock     (clock),
      .ctrl      (mul_ctrl),
      .cand_num  (cand_num_ff),
      .cand_den  (cand_den_ff),
      .best_num  (best_num_ff),
      .best_den  (best_den_ff),
      .cand_wins (cand_wins)
   );

   // Sequencer: next state, datapath updates and result selection.
   always_comb begin
      state_in         = state_ff;
      scan_idx_in      = scan_idx_ff;
      count_in         = count_ff;
      best_found_in    = best_found_ff;
      best_idx_in      = best_idx_ff;
      best_tag_in      = best_tag_ff;
      best_mem_in      = best_mem_ff;
      best_tape_in     = best_tape_ff;
      best_prn_in      = best_prn_ff;
      best_num_in      = best_num_ff;
      best_den_in      = best_den_ff;
      cand_tag_in      = cand_tag_ff;
      cand_mem_in      = cand_mem_ff;
      cand_tape_in     = cand_tape_ff;
      cand_prn_in      = cand_prn_ff;
      cand_num_in      = cand_num_ff;
      cand_den_in      = cand_den_ff;
      pend_valid_in    = pend_valid_ff;
      pend_tag_in      = pend_tag_ff;
      pend_slot_in     = pend_slot_ff;
      pend_mem_in      = pend_mem_ff;
      slot_valid_in    = slot_valid_ff;
      slots_used_in    = slots_used_ff;
      mem_free_in      = mem_free_ff;
      tapes_free_in    = tapes_free_ff;
      printers_free_in = printers_free_ff;
      job_we           = 1'b0;
      mul_ctrl         = '0;
      rsp_valid_in     = 1'b0;
      rsp_kind_in      = rsp_kind_ff;
      rsp_status_in    = STAT_OK;
      rsp_tag_in       = rsp_tag_ff;
      rsp_slot_in      = rsp_slot_ff;
      rsp_mem_in       = mem_free_ff;
      rsp_last_in      = 1'b1;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               unique case (req_action)
                  ACT_ADD: begin
                     rsp_valid_in = 1'b1;
                     rsp_kind_in  = KIND_ADD_ACK;
                     rsp_tag_in   = req_job_tag;
                     rsp_slot_in  = '0;
                     if (table_full) begin
                        rsp_status_in = STAT_FULL;
                     end else if (req_run_time == '0) begin
                        rsp_status_in = STAT_ZERO_RUN;
                     end else begin
                        job_we = 1'b1;
                        slot_valid_in[slots_used_ff[SLOT_W-1:0]] = 1'b1;
                        slots_used_in = slots_used_ff + USED_W'(1);
                        rsp_slot_in   = OUT_SLOT_W'(slots_used_ff);
                     end
                  end
                  ACT_SCHEDULE: begin
                     state_in      = ST_FETCH;
                     scan_idx_in   = SLOT_W'(JOB_SLOTS - 1);
                     count_in      = '0;
                     best_found_in = 1'b0;
                     pend_valid_in = 1'b0;
                  end
                  ACT_CLEAR: begin
                     slot_valid_in    = '0;
                     slots_used_in    = '0;
                     mem_free_in      = total_memory_ff;
                     tapes_free_in    = total_tapes_ff;
                     printers_free_in = total_printers_ff;
                     rsp_valid_in     = 1'b1;
                     rsp_kind_in      = KIND_CLEARED;
                     rsp_tag_in       = '0;
                     rsp_slot_in      = '0;
                     rsp_mem_in       = total_memory_ff;
                  end
                  ACT_UNUSED: begin
                  end
               endcase
            end
         end

         ST_FETCH: begin
            cand_tag_in  = rd_tag;
            cand_mem_in  = rd_mem;
            cand_tape_in = rd_tape;
            cand_prn_in  = rd_prn;
            cand_num_in  = rd_num;
            cand_den_in  = rd_den;
            if (rd_fits && best_found_ff) begin
               state_in = ST_MUL1;
            end else begin
               // The first fitting job of a pass is taken without a compare.
               if (rd_fits) begin
                  best_found_in = 1'b1;
                  best_idx_in   = scan_idx_ff;
                  best_tag_in   = rd_tag;
                  best_mem_in   = rd_mem;
                  best_tape_in  = rd_tape;
                  best_prn_in   = rd_prn;
                  best_num_in   = rd_num;
                  best_den_in   = rd_den;
               end
               if (scan_done) begin
                  state_in = ST_PICK;
               end else begin
                  scan_idx_in = scan_idx_ff - SLOT_W'(1);
               end
            end
         end

         ST_MUL1: begin
            mul_ctrl.load_first = 1'b1;
            state_in = ST_MUL2;
         end

         ST_MUL2: begin
            mul_ctrl.load_second = 1'b1;
            state_in = ST_CMP;
         end

         ST_CMP: begin
            if (cand_wins) begin
               best_idx_in  = scan_idx_ff;
               best_tag_in  = cand_tag_ff;
               best_mem_in  = cand_mem_ff;
               best_tape_in = cand_tape_ff;
               best_prn_in  = cand_prn_ff;
               best_num_in  = cand_num_ff;
               best_den_in  = cand_den_ff;
            end
            if (scan_done) begin
               state_in = ST_PICK;
            end else begin
               scan_idx_in = scan_idx_ff - SLOT_W'(1);
               state_in    = ST_FETCH;
            end
         end

         ST_PICK: begin
            rsp_kind_in = KIND_PICKED;
            rsp_tag_in  = pend_tag_ff;
            rsp_slot_in = OUT_SLOT_W'(pend_slot_ff);
            rsp_mem_in  = pend_mem_ff;
            if (best_found_ff) begin
               // Show the previous pick, which is now known not to be last.
               rsp_valid_in = pend_valid_ff;
               rsp_last_in  = 1'b0;
               slot_valid_in[best_idx_ff] = 1'b0;
               mem_free_in      = mem_after_pick;
               tapes_free_in    = tapes_free_ff - best_tape_ff;
               printers_free_in = printers_free_ff - best_prn_ff;
               pend_valid_in    = 1'b1;
               pend_tag_in      = best_tag_ff;
               pend_slot_in     = best_idx_ff;
               pend_mem_in      = mem_after_pick;
               count_in         = count_ff + CNT_W'(1);
               best_found_in    = 1'b0;
               scan_idx_in      = SLOT_W'(JOB_SLOTS - 1);
               if (count_ff == CNT_W'(MAX_PICKS - 1)) begin
                  state_in = ST_FLUSH;
               end else begin
                  state_in = ST_FETCH;
               end
            end else begin
               rsp_valid_in = 1'b1;
               if (!pend_valid_ff) begin
                  rsp_kind_in = KIND_NONE_FITS;
                  rsp_tag_in  = '0;
                  rsp_slot_in = '0;
                  rsp_mem_in  = mem_free_ff;
               end
               pend_valid_in = 1'b0;
               state_in      = ST_IDLE;
            end
         end

         ST_FLUSH: begin
            rsp_valid_in  = 1'b1;
            rsp_kind_in   = KIND_PICKED;
            rsp_tag_in    = pend_tag_ff;
            rsp_slot_in   = OUT_SLOT_W'(pend_slot_ff);
            rsp_mem_in    = pend_mem_ff;
            pend_valid_in = 1'b0;
            state_in      = ST_IDLE;
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Control state and the pool.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= ST_IDLE;
         scan_idx_ff      <= '0;
         count_ff         <= '0;
         best_found_ff    <= 1'b0;
         pend_valid_ff    <= 1'b0;
         slot_valid_ff    <= '0;
         slots_used_ff    <= '0;
         mem_free_ff      <= RESET_MEMORY;
         tapes_free_ff    <= RESET_TAPES;
         printers_free_ff <= RESET_PRINTERS;
         rsp_valid_ff     <= 1'b0;
      end else begin
         state_ff         <= state_in;
         scan_idx_ff      <= scan_idx_in;
         count_ff         <= count_in;
         best_found_ff    <= best_found_in;
         pend_valid_ff    <= pend_valid_in;
         slot_valid_ff    <= slot_valid_in;
         slots_used_ff    <= slots_used_in;
         mem_free_ff      <= mem_free_in;
         tapes_free_ff    <= tapes_free_in;
         printers_free_ff <= printers_free_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
   end

   // Configuration registers; an index beyond the list writes nothing.
   always_ff @(posedge clock) begin
      if (reset) begin
         total_memory_ff   <= RESET_MEMORY;
         total_tapes_ff    <= RESET_TAPES;
         total_printers_ff <= RESET_PRINTERS;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_TOTAL_MEMORY:   total_memory_ff   <= csr_wdata[MEM_W-1:0];
            CSR_TOTAL_TAPES:    total_tapes_ff    <= csr_wdata[DEV_W-1:0];
            CSR_TOTAL_PRINTERS: total_printers_ff <= csr_wdata[DEV_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      best_idx_ff   <= best_idx_in;
      best_tag_ff   <= best_tag_in;
      best_mem_ff   <= best_mem_in;
      best_tape_ff  <= best_tape_in;
      best_prn_ff   <= best_prn_in;
      best_num_ff   <= best_num_in;
      best_den_ff   <= best_den_in;
      cand_tag_ff   <= cand_tag_in;
      cand_mem_ff   <= cand_mem_in;
      cand_tape_ff  <= cand_tape_in;
      cand_prn_ff   <= cand_prn_in;
      cand_num_ff   <= cand_num_in;
      cand_den_ff   <= cand_den_in;
      pend_tag_ff   <= pend_tag_in;
      pend_slot_ff  <= pend_slot_in;
      pend_mem_ff   <= pend_mem_in;
      rsp_kind_ff   <= rsp_kind_in;
      rsp_status_ff <= rsp_status_in;
      rsp_tag_ff    <= rsp_tag_in;
      rsp_slot_ff   <= rsp_slot_in;
      rsp_mem_ff    <= rsp_mem_in;
      rsp_last_ff   <= rsp_last_in;
   end

   // Job table entries are written only by an accepted add.
   always_ff @(posedge clock) begin
      if (job_we) begin
         job_tag_ff[slots_used_ff[SLOT_W-1:0]]  <= req_job_tag;
         job_mem_ff[slots_used_ff[SLOT_W-1:0]]  <= req_mem_need;
         job_tape_ff[slots_used_ff[SLOT_W-1:0]] <= req_tape_need;
         job_prn_ff[slots_used_ff[SLOT_W-1:0]]  <= req_printer_need;
         job_wait_ff[slots_used_ff[SLOT_W-1:0]] <= req_wait_time;
         job_run_ff[slots_used_ff[SLOT_W-1:0]]  <= req_run_time;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_kind        = rsp_kind_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_picked_tag  = rsp_tag_ff;
   assign rsp_picked_slot = rsp_slot_ff;
   assign rsp_free_memory = rsp_mem_ff;
   assign rsp_last        = rsp_last_ff;

`ifndef SYNTHESIS
   // An unused action code never produces a result.
   a_unused_silent: assert property (@(posedge clock) disable iff (reset)
      (accept && req_action == ACT_UNUSED) |=> !rsp_valid)
      else $error("result produced for an unused action");

   // An add acknowledge only follows an accepted command.
   a_ack_follows_accept: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_kind == KIND_ADD_ACK) |-> $past(accept))
      else $error("add acknowledge without an accepted command");

   // The fill count never passes the table size.
   a_used_bound: assert property (@(posedge clock) disable iff (reset)
      slots_used_ff <= USED_W'(JOB_SLOTS))
      else $error("slot count beyond table size");

   // A pass never runs after the pick limit.
   a_pick_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_FETCH) |-> (count_ff < CNT_W'(MAX_PICKS)))
      else $error("scan started after the pick limit");
`endif

endmodule
